// ===== design/kc_pkg.sv =====
// Package for the keypad calculator: key decode tables, operator codes and the microcode ROM.
`timescale 1ns / 1ps

package kc_pkg;

  // Widths of the fixed stream fields
  localparam int KEY_BITS           = 5;
  localparam int FIELD_BITS         = 16;
  localparam int IN_TDATA_BITS      = 8;
  localparam int OUT_TDATA_BITS     = 56;
  localparam int DEF_OPERAND_BITS   = 16;

  // Key codes of the non-digit, non-operator keys
  localparam logic [KEY_BITS-1:0] KEY_CLEAR  = 5'd14;
  localparam logic [KEY_BITS-1:0] KEY_EQUALS = 5'd15;

  // Stored operator
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  // Kind of key
  typedef enum logic [2:0] {
    KC_UNKNOWN,
    KC_DIGIT,
    KC_OPER,
    KC_CLEAR,
    KC_EQUALS
  } kclass_t;

  // Datapath action of one microcode step
  typedef enum logic [3:0] {
    A_NOP,
    A_LATCH,
    A_DIGIT,
    A_SETOP,
    A_CLEAR,
    A_ADD,
    A_SUB,
    A_MUL_INIT,
    A_MUL_STEP,
    A_MUL_END,
    A_DIV_INIT,
    A_DIV_STEP,
    A_DIV_END,
    A_DIV_ZERO,
    A_EMIT
  } act_t;

  // Sequencing of one microcode step
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_WAIT_IN,
    C_DISPATCH,
    C_LOOP,
    C_WAIT_OUT
  } cond_t;

  localparam int UPC_BITS = 4;
  typedef logic [UPC_BITS-1:0] upc_t;

  // Step addresses
  localparam upc_t S_IDLE    = 4'd0;
  localparam upc_t S_DECODE  = 4'd1;
  localparam upc_t S_DIGIT   = 4'd2;
  localparam upc_t S_SETOP   = 4'd3;
  localparam upc_t S_CLEAR   = 4'd4;
  localparam upc_t S_ADD     = 4'd5;
  localparam upc_t S_SUB     = 4'd6;
  localparam upc_t S_MULI    = 4'd7;
  localparam upc_t S_MULS    = 4'd8;
  localparam upc_t S_MULE    = 4'd9;
  localparam upc_t S_DIVI    = 4'd10;
  localparam upc_t S_DIVS    = 4'd11;
  localparam upc_t S_DIVE    = 4'd12;
  localparam upc_t S_DIVZ    = 4'd13;
  localparam upc_t S_EMIT    = 4'd14;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uop_t;

  // Microcode ROM: one control word per step
  function automatic uop_t ucode_rom(input upc_t pc);
    uop_t u;
    u = '{act: A_NOP, cond: C_GOTO, target: S_IDLE};
    unique case (pc)
      S_IDLE:   u = '{act: A_LATCH,    cond: C_WAIT_IN,  target: S_DECODE};
      S_DECODE: u = '{act: A_NOP,      cond: C_DISPATCH, target: S_EMIT};
      S_DIGIT:  u = '{act: A_DIGIT,    cond: C_GOTO,     target: S_EMIT};
      S_SETOP:  u = '{act: A_SETOP,    cond: C_GOTO,     target: S_EMIT};
      S_CLEAR:  u = '{act: A_CLEAR,    cond: C_GOTO,     target: S_EMIT};
      S_ADD:    u = '{act: A_ADD,      cond: C_GOTO,     target: S_EMIT};
      S_SUB:    u = '{act: A_SUB,      cond: C_GOTO,     target: S_EMIT};
      S_MULI:   u = '{act: A_MUL_INIT, cond: C_NEXT,     target: S_MULS};
      S_MULS:   u = '{act: A_MUL_STEP, cond: C_LOOP,     target: S_MULE};
      S_MULE:   u = '{act: A_MUL_END,  cond: C_GOTO,     target: S_EMIT};
      S_DIVI:   u = '{act: A_DIV_INIT, cond: C_NEXT,     target: S_DIVS};
      S_DIVS:   u = '{act: A_DIV_STEP, cond: C_LOOP,     target: S_DIVE};
      S_DIVE:   u = '{act: A_DIV_END,  cond: C_GOTO,     target: S_EMIT};
      S_DIVZ:   u = '{act: A_DIV_ZERO, cond: C_GOTO,     target: S_EMIT};
      S_EMIT:   u = '{act: A_EMIT,     cond: C_WAIT_OUT, target: S_IDLE};
      default:  u = '{act: A_NOP,      cond: C_GOTO,     target: S_IDLE};
    endcase
    return u;
  endfunction

  // Classify a key code
  function automatic kclass_t key_class(input logic [KEY_BITS-1:0] key);
    kclass_t k;
    k = KC_UNKNOWN;
    unique case (key)
      5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7,
      5'd9, 5'd10, 5'd11, 5'd13:      k = KC_DIGIT;
      5'd4, 5'd8, 5'd12, 5'd16:       k = KC_OPER;
      KEY_CLEAR:                      k = KC_CLEAR;
      KEY_EQUALS:                     k = KC_EQUALS;
      default:                        k = KC_UNKNOWN;
    endcase
    return k;
  endfunction

  // Digit value of a digit key
  function automatic logic [3:0] key_digit(input logic [KEY_BITS-1:0] key);
    logic [3:0] d;
    d = 4'd0;
    unique case (key)
      5'd1:    d = 4'd7;
      5'd2:    d = 4'd8;
      5'd3:    d = 4'd9;
      5'd5:    d = 4'd4;
      5'd6:    d = 4'd5;
      5'd7:    d = 4'd6;
      5'd9:    d = 4'd1;
      5'd10:   d = 4'd2;
      5'd11:   d = 4'd3;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  // Operator of an operator key
  function automatic op_t key_op(input logic [KEY_BITS-1:0] key);
    op_t o;
    o = OP_NONE;
    unique case (key)
      5'd4:    o = OP_ADD;
      5'd8:    o = OP_SUB;
      5'd12:   o = OP_MUL;
      5'd16:   o = OP_DIV;
      default: o = OP_NONE;
    endcase
    return o;
  endfunction

endpackage

// ===== design/keypad_calculator_top.sv =====
// Keypad calculator: microcoded sequencer over a shift-add multiply and restoring divide datapath.
`timescale 1ns / 1ps

// Channel | Dir | tdata fields (lowest bit up)
// in_     | in  | key_code[4:0], zero pad to 8 bits
// out_    | out | first_operand[15:0], second_operand[31:16], operator_code[34:32],
//         |     | result_value[50:35], result_updated[51], divide_by_zero[52], pad [55:53]
//
// An unknown key or equals without an operator runs the latch, decode and emit steps;
// a digit, an operator, clear, add, subtract and divide by zero add one action step before emit.
// Multiply and divide add an init step, one loop step per operand bit and an end step;
// the loop handles one operand bit per step.
// A new key is taken once the previous request has been placed in the output
// register; a stalled output holds the sequencer in its emit step.
// rst_n clears all operands, the operator, the result, both flags and the output valid.

module keypad_calculator_top #(
  parameter int OPERAND_BITS = kc_pkg::DEF_OPERAND_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kc_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // key_code
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kc_pkg::OUT_TDATA_BITS-1:0]  out_tdata   // first, second, op, result, upd, dz
);
  import kc_pkg::*;

  localparam int W        = OPERAND_BITS;
  localparam int CNT_BITS = $clog2(OPERAND_BITS);
  localparam int PAD_BITS = OUT_TDATA_BITS - 3 * FIELD_BITS - 3 - 2;

  // Architectural state
  logic [W-1:0]          first_r, first_nxt;
  logic [W-1:0]          second_r, second_nxt;
  op_t                   op_r, op_nxt;
  logic                  entering_r, entering_nxt;
  logic [W-1:0]          result_r, result_nxt;
  logic                  updated_r, updated_nxt;
  logic                  divz_r, divz_nxt;

  // Sequencer and working registers
  upc_t                  pc_r, pc_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [W-1:0]          acc_r, acc_nxt;     // product accumulator / remainder
  logic [W-1:0]          wb_r, wb_nxt;       // multiplicand / quotient
  logic [W-1:0]          wc_r, wc_nxt;       // multiplier
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;

  // Output register
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_BITS-1:0]     out_tdata_r, out_tdata_nxt;

  uop_t                  uop;
  logic                  in_fire;
  logic                  out_free;
  logic                  cnt_last;
  upc_t                  dispatch_pc;
  logic [W-1:0]          operand_sel;
  logic [W-1:0]          digit_val;
  logic [W:0]            div_shift;
  logic [W:0]            div_diff;
  logic [W+FIELD_BITS-1:0] first_ext, second_ext, result_ext;

  assign uop       = ucode_rom(pc_r);
  assign in_tready = (uop.cond == C_WAIT_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cnt_last  = (cnt_r == CNT_BITS'(OPERAND_BITS - 1));

  // Decimal shift: x*10 + d as (x<<3) + (x<<1) + d
  assign operand_sel = entering_r ? second_r : first_r;
  assign digit_val   = {operand_sel[W-4:0], 3'b000} + {operand_sel[W-2:0], 1'b0}
                       + W'(key_digit(key_r));

  // One restoring division step
  assign div_shift = {acc_r, wb_r[W-1]};
  assign div_diff  = div_shift - {1'b0, second_r};

  // Fit values to the 16-bit output fields
  assign first_ext  = {{FIELD_BITS{1'b0}}, first_r};
  assign second_ext = {{FIELD_BITS{1'b0}}, second_r};
  assign result_ext = {{FIELD_BITS{1'b0}}, result_r};

  // Pick the routine for the latched key
  always_comb begin
    dispatch_pc = S_EMIT;
    unique case (key_class(key_r))
      KC_DIGIT:  dispatch_pc = S_DIGIT;
      KC_OPER:   dispatch_pc = S_SETOP;
      KC_CLEAR:  dispatch_pc = S_CLEAR;
      KC_EQUALS: begin
        unique case (op_r)
          OP_ADD:  dispatch_pc = S_ADD;
          OP_SUB:  dispatch_pc = S_SUB;
          OP_MUL:  dispatch_pc = S_MULI;
          OP_DIV:  dispatch_pc = (second_r == '0) ? S_DIVZ : S_DIVI;
          default: dispatch_pc = S_EMIT;
        endcase
      end
      default:   dispatch_pc = S_EMIT;
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    first_nxt      = first_r;
    second_nxt     = second_r;
    op_nxt         = op_r;
    entering_nxt   = entering_r;
    result_nxt     = result_r;
    updated_nxt    = updated_r;
    divz_nxt       = divz_r;
    key_nxt        = key_r;
    acc_nxt        = acc_r;
    wb_nxt         = wb_r;
    wc_nxt         = wc_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    pc_nxt         = pc_r;

    // Next step
    unique case (uop.cond)
      C_NEXT:     pc_nxt = pc_r + 1'b1;
      C_GOTO:     pc_nxt = uop.target;
      C_WAIT_IN:  if (in_fire) pc_nxt = uop.target;
      C_DISPATCH: pc_nxt = dispatch_pc;
      C_LOOP:     if (cnt_last) pc_nxt = uop.target;
      C_WAIT_OUT: if (out_free) pc_nxt = uop.target;
      default:    pc_nxt = S_IDLE;
    endcase

    // Datapath action
    unique case (uop.act)
      A_LATCH: begin
        if (in_fire) begin
          key_nxt     = in_tdata[KEY_BITS-1:0];
          updated_nxt = 1'b0;
          divz_nxt    = 1'b0;
        end
      end
      A_DIGIT: begin
        if (entering_r) second_nxt = digit_val;
        else            first_nxt  = digit_val;
      end
      A_SETOP: begin
        op_nxt       = key_op(key_r);
        entering_nxt = 1'b1;
      end
      A_CLEAR: begin
        first_nxt    = '0;
        second_nxt   = '0;
        op_nxt       = OP_NONE;
        entering_nxt = 1'b0;
        result_nxt   = '0;
      end
      A_ADD: begin
        result_nxt  = first_r + second_r;
        updated_nxt = 1'b1;
      end
      A_SUB: begin
        result_nxt  = first_r - second_r;
        updated_nxt = 1'b1;
      end
      A_MUL_INIT: begin
        acc_nxt = '0;
        wb_nxt  = first_r;
        wc_nxt  = second_r;
        cnt_nxt = '0;
      end
      A_MUL_STEP: begin
        if (wc_r[0]) acc_nxt = acc_r + wb_r;
        wb_nxt  = {wb_r[W-2:0], 1'b0};
        wc_nxt  = {1'b0, wc_r[W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
      end
      A_MUL_END: begin
        result_nxt  = acc_r;
        updated_nxt = 1'b1;
      end
      A_DIV_INIT: begin
        acc_nxt = '0;
        wb_nxt  = first_r;
        cnt_nxt = '0;
      end
      A_DIV_STEP: begin
        // Keep the difference when the shifted remainder covers the divisor
        if (!div_diff[W]) begin
          acc_nxt = div_diff[W-1:0];
          wb_nxt  = {wb_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = div_shift[W-1:0];
          wb_nxt  = {wb_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      A_DIV_END: begin
        result_nxt  = wb_r;
        updated_nxt = 1'b1;
      end
      A_DIV_ZERO: begin
        result_nxt  = '1;
        updated_nxt = 1'b1;
        divz_nxt    = 1'b1;
      end
      A_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PAD_BITS{1'b0}}, divz_r, updated_r,
                            result_ext[FIELD_BITS-1:0], op_r,
                            second_ext[FIELD_BITS-1:0], first_ext[FIELD_BITS-1:0]};
        end
      end
      default: begin
        pc_nxt = pc_nxt;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= S_IDLE;
      first_r      <= '0;
      second_r     <= '0;
      op_r         <= OP_NONE;
      entering_r   <= 1'b0;
      result_r     <= '0;
      updated_r    <= 1'b0;
      divz_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      op_r         <= op_nxt;
      entering_r   <= entering_nxt;
      result_r     <= result_nxt;
      updated_r    <= updated_nxt;
      divz_r       <= divz_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    key_r       <= key_nxt;
    acc_r       <= acc_nxt;
    wb_r        <= wb_nxt;
    wc_r        <= wc_nxt;
    cnt_r       <= cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
